// ===== design/pms_pkg.sv =====
package pms_pkg;

	localparam int unsigned WORD_W      = 16;
	localparam int unsigned GAIN_W      = 16;
	localparam int unsigned RATIO_W     = 8;
	localparam int unsigned LIMIT_W     = 7;
	localparam int unsigned FS_W        = 3;
	localparam int unsigned PRESCALE_W  = 4;
	localparam int unsigned COUNTER_W   = 32;
	localparam int unsigned REM_STEP_W  = 4;
	localparam int unsigned REM_STEPS   = COUNTER_W / REM_STEP_W;

	localparam logic [FS_W-1:0] FS_MIN     = 3'd1;
	localparam logic [FS_W-1:0] FS_MAX     = 3'd5;
	localparam int unsigned     TEMPO_BASE = 6;

	localparam logic [GAIN_W-1:0]         GAIN_RESET  = 16'd256;
	localparam logic signed [WORD_W-1:0] UPPER_RESET = 16'sd100;

	// configuration register indexes
	localparam logic [1:0] CFG_GAIN  = 2'd0;
	localparam logic [1:0] CFG_FREQ  = 2'd1;
	localparam logic [1:0] CFG_PWM   = 2'd2;

	typedef enum logic [1:0] {
		REQ_TICK = 2'd0,
		REQ_WORD = 2'd1,
		REQ_CHAN = 2'd2
	} req_t;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef struct packed {
		logic                 is_pwm;
		logic signed [WORD_W-1:0] lo;
		logic signed [WORD_W-1:0] hi;
		logic [LIMIT_W-1:0]   pwm_limit;
	} goal_ctl_t;

	typedef struct packed {
		logic               start;
		logic [RATIO_W-1:0] divisor;
	} rem_ctl_t;

	// prescaler wrap point for a tempo setting, tempo clamped to its range
	function automatic logic [PRESCALE_W-1:0] prescale_wrap(input logic [FS_W-1:0] fs);
		logic [FS_W-1:0] f;
		f = fs;
		if (fs < FS_MIN) f = FS_MIN;
		else if (fs > FS_MAX) f = FS_MAX;
		return PRESCALE_W'(2 * (TEMPO_BASE - int'(f)));
	endfunction

endpackage

// ===== design/pms_ram.sv =====
module pms_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/pms_rem.sv =====
module pms_rem (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pms_pkg::rem_ctl_t                ctl,
	input  logic [pms_pkg::COUNTER_W-1:0]    dividend,
	output logic                             done,
	output logic [pms_pkg::RATIO_W-1:0]      rem
);

	import pms_pkg::*;

	localparam int unsigned CNT_W = $clog2(REM_STEPS);

	typedef enum logic {R_IDLE, R_RUN} rstate_t;

	rstate_t              state_q;
	logic [COUNTER_W-1:0] dvd_q;
	logic [RATIO_W-1:0]   div_q;
	logic [RATIO_W-1:0]   rem_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 done_q;
	logic [RATIO_W-1:0]   rem_next;

	// restoring remainder, a few dividend bits per cycle
	always_comb begin
		logic [RATIO_W:0]   t;
		logic [RATIO_W-1:0] r;
		r = rem_q;
		for (int i = 0; i < REM_STEP_W; i++) begin
			t = {r, dvd_q[COUNTER_W-1-i]};
			if (t >= {1'b0, div_q}) t = t - {1'b0, div_q};
			r = t[RATIO_W-1:0];
		end
		rem_next = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			rem_q   <= '0;
			dvd_q   <= '0;
			div_q   <= RATIO_W'(1);
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				R_IDLE: begin
					if (ctl.start) begin
						dvd_q   <= dividend;
						div_q   <= (ctl.divisor == '0) ? RATIO_W'(1) : ctl.divisor;
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= R_RUN;
					end
				end
				R_RUN: begin
					rem_q <= rem_next;
					dvd_q <= dvd_q << REM_STEP_W;
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(REM_STEPS - 1)) begin
						state_q <= R_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// ===== design/pms_goal.sv =====
module pms_goal (
	input  logic                        clk,
	input  pms_pkg::word_t              word_in,
	input  logic [pms_pkg::GAIN_W-1:0]  gain,
	input  pms_pkg::goal_ctl_t          ctl,
	output pms_pkg::word_t              goal
);

	import pms_pkg::*;

	localparam int unsigned PROD_W = WORD_W + GAIN_W + 1;

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [PROD_W-1:0] quo;
	word_t                    sat;
	word_t                    val;

	always_ff @(posedge clk) begin
		prod_s1 <= word_in * $signed({1'b0, gain});
	end

	always_comb begin
		// divide by 256 rounding toward zero
		quo = (prod_s1 + (prod_s1[PROD_W-1] ? PROD_W'(255) : PROD_W'(0))) >>> 8;
		if (quo > PROD_W'(32767)) sat = 16'sh7fff;
		else if (quo < -PROD_W'(32768)) sat = 16'sh8000;
		else sat = quo[WORD_W-1:0];
		val = sat;
		if (val > ctl.hi) val = ctl.hi;
		if (val < ctl.lo) val = ctl.lo;
		if (ctl.is_pwm && val > $signed({{(WORD_W-LIMIT_W){1'b0}}, ctl.pwm_limit}))
			val = $signed({{(WORD_W-LIMIT_W){1'b0}}, ctl.pwm_limit});
		goal = val;
	end

endmodule

// ===== design/multichannel_pattern_sequencer_top.sv =====
// multichannel pattern sequencer
// command channel: an item is taken on a clock edge with start high and busy low.
// req_type selects a timer tick, a table word write (channel, index, word) or a
// channel settings write (channel, enable, ratio, bound_lo, bound_hi).
// writes, and a tick that does not wrap the prescaler, complete without raising busy;
// writes give no result. a wrapping tick bumps the step counter and walks the
// channels one by one: a disabled channel is skipped in S_CHK, an enabled one waits
// in S_MOD for the remainder check in the shared 4-bit-per-cycle unit (8 passes
// over the 32-bit counter), then goes through S_READ and S_SCALE for table read and
// scaling if it fires; S_FLUSH ends the tick.
// results come out on out_channel/goal/last with out_valid high for one cycle,
// in ascending channel order; a result goes out when the next firing channel is
// scaled or in the flush state, where last marks the final one of the tick.
// the receiver cannot stall the block.
// configuration port: cfg_valid/cfg_ready with cfg_index and cfg_data, always ready.
// the user must see it is written only while idle; the block does not enforce it.
// after reset the pattern table is cleared one word a cycle, NUM_CHANNELS*PATTERN_LEN
// words (512 by default), with busy high; configuration writes are taken meanwhile.
module multichannel_pattern_sequencer_top #(
	parameter int unsigned NUM_CHANNELS = 8,
	parameter int unsigned PATTERN_LEN  = 64,
	parameter int unsigned PWM_CHANNELS = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [2:0]  channel,
	input  logic [5:0]  index,
	input  logic signed [15:0] word,
	input  logic        enable,
	input  logic [7:0]  ratio,
	input  logic signed [15:0] bound_lo,
	input  logic signed [15:0] bound_hi,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        out_valid,
	output logic [2:0]  out_channel,
	output logic signed [15:0] goal,
	output logic        last
);

	import pms_pkg::*;

	localparam int unsigned DEPTH = NUM_CHANNELS * PATTERN_LEN;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int unsigned POS_W = $clog2(PATTERN_LEN);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_CHK, S_MOD, S_READ, S_SCALE, S_FLUSH
	} state_t;

	state_t state_q;

	logic [GAIN_W-1:0]     gain_q;
	logic [FS_W-1:0]       fs_q;
	logic [LIMIT_W-1:0]    pwm_limit_q;

	logic [PRESCALE_W-1:0] prescale_q;
	logic [COUNTER_W-1:0]  step_q;
	logic [AW-1:0]         clr_q;
	logic [CH_W-1:0]       ch_q;

	logic                  enable_q [NUM_CHANNELS];
	logic [RATIO_W-1:0]    ratio_q  [NUM_CHANNELS];
	word_t                 lo_q     [NUM_CHANNELS];
	word_t                 hi_q     [NUM_CHANNELS];
	logic [POS_W-1:0]      pos_q    [NUM_CHANNELS];

	logic                  have_pend_q;
	logic [CH_W-1:0]       pend_ch_q;
	word_t                 pend_goal_q;

	logic                  out_valid_q;
	logic [2:0]            out_channel_q;
	word_t                 goal_q;
	logic                  last_q;

	logic                  accept;
	req_t                  req;
	logic                  ch_ok;
	logic                  idx_ok;
	logic [CH_W-1:0]       wr_ch;
	logic [PRESCALE_W-1:0] pc_next;
	logic [PRESCALE_W-1:0] wrap;
	logic                  last_ch;
	logic [POS_W-1:0]      pos_cur;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [WORD_W-1:0]     ram_wdata;
	logic [AW-1:0]         ram_raddr;
	logic [WORD_W-1:0]     ram_rdata;

	rem_ctl_t              rem_ctl;
	logic                  rem_done;
	logic [RATIO_W-1:0]    rem_val;

	goal_ctl_t             goal_ctl;
	word_t                 goal_val;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign req       = req_t'(req_type);
	assign ch_ok     = 32'(channel) < NUM_CHANNELS;
	assign idx_ok    = 32'(index) < PATTERN_LEN;
	assign wr_ch     = CH_W'(channel);
	assign pc_next   = prescale_q + PRESCALE_W'(1);
	assign wrap      = prescale_wrap(fs_q);
	assign last_ch   = (ch_q == CH_W'(NUM_CHANNELS - 1));
	assign pos_cur   = pos_q[ch_q];
	assign cfg_ready = 1'b1;

	// table port: clearing sweep after reset, else word writes
	assign ram_we    = (state_q == S_CLEAR) ||
	                   (accept && req == REQ_WORD && ch_ok && idx_ok);
	assign ram_waddr = (state_q == S_CLEAR) ? clr_q :
	                   AW'(32'(channel) * PATTERN_LEN + 32'(index));
	assign ram_wdata = (state_q == S_CLEAR) ? '0 : word;
	assign ram_raddr = AW'(32'(ch_q) * PATTERN_LEN + 32'(pos_cur));

	assign rem_ctl.start   = (state_q == S_CHK) && enable_q[ch_q];
	assign rem_ctl.divisor = ratio_q[ch_q];

	assign goal_ctl.is_pwm    = (32'(ch_q) + PWM_CHANNELS) >= NUM_CHANNELS;
	assign goal_ctl.lo        = lo_q[ch_q];
	assign goal_ctl.hi        = hi_q[ch_q];
	assign goal_ctl.pwm_limit = pwm_limit_q;

	pms_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	pms_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (rem_ctl),
		.dividend (step_q),
		.done     (rem_done),
		.rem      (rem_val)
	);

	pms_goal u_goal (
		.clk     (clk),
		.word_in ($signed(ram_rdata)),
		.gain    (gain_q),
		.ctl     (goal_ctl),
		.goal    (goal_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q      <= GAIN_RESET;
			fs_q        <= FS_MIN;
			pwm_limit_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_GAIN: gain_q      <= cfg_data[GAIN_W-1:0];
				CFG_FREQ: fs_q        <= cfg_data[FS_W-1:0];
				CFG_PWM:  pwm_limit_q <= cfg_data[LIMIT_W-1:0];
				default:  ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			prescale_q  <= '0;
			step_q      <= '0;
			ch_q        <= '0;
			have_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				enable_q[c] <= 1'b0;
				ratio_q[c]  <= RATIO_W'(1);
				lo_q[c]     <= '0;
				hi_q[c]     <= UPPER_RESET;
				pos_q[c]    <= '0;
			end
		end else begin
			out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						unique case (req)
							REQ_TICK: begin
								if (pc_next < wrap) begin
									prescale_q <= pc_next;
								end else begin
									prescale_q <= '0;
									step_q     <= step_q + COUNTER_W'(1);
									ch_q       <= '0;
									state_q    <= S_CHK;
								end
							end
							REQ_CHAN: begin
								if (ch_ok) begin
									enable_q[wr_ch] <= enable;
									ratio_q[wr_ch]  <= (ratio == '0) ? RATIO_W'(1) : ratio;
									lo_q[wr_ch]     <= bound_lo;
									hi_q[wr_ch]     <= bound_hi;
								end
							end
							default: ;
						endcase
					end
				end
				S_CHK: begin
					if (enable_q[ch_q]) begin
						state_q <= S_MOD;
					end else if (last_ch) begin
						state_q <= S_FLUSH;
					end else begin
						ch_q    <= ch_q + CH_W'(1);
						state_q <= S_CHK;
					end
				end
				S_MOD: begin
					if (rem_done) begin
						if (rem_val == '0) begin
							state_q <= S_READ;
						end else if (last_ch) begin
							state_q <= S_FLUSH;
						end else begin
							ch_q    <= ch_q + CH_W'(1);
							state_q <= S_CHK;
						end
					end
				end
				S_READ: state_q <= S_SCALE;
				S_SCALE: begin
					// hold each result until the next one shows whether it is the last
					if (have_pend_q) begin
						out_valid_q   <= 1'b1;
						out_channel_q <= 3'(pend_ch_q);
						goal_q        <= pend_goal_q;
						last_q        <= 1'b0;
					end
					have_pend_q <= 1'b1;
					pend_ch_q   <= ch_q;
					pend_goal_q <= goal_val;
					pos_q[ch_q] <= (pos_cur == POS_W'(PATTERN_LEN - 1)) ? '0
					               : pos_cur + POS_W'(1);
					if (last_ch) begin
						state_q <= S_FLUSH;
					end else begin
						ch_q    <= ch_q + CH_W'(1);
						state_q <= S_CHK;
					end
				end
				S_FLUSH: begin
					if (have_pend_q) begin
						out_valid_q   <= 1'b1;
						out_channel_q <= 3'(pend_ch_q);
						goal_q        <= pend_goal_q;
						last_q        <= 1'b1;
					end
					have_pend_q <= 1'b0;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign out_channel = out_channel_q;
	assign goal        = goal_q;
	assign last        = last_q;

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $past(state_q == S_SCALE || state_q == S_FLUSH))
		else $error("result strobe outside scale or flush");

	a_rem_owner: assert property (@(posedge clk) disable iff (!arst_n)
		rem_done |-> state_q == S_MOD)
		else $error("remainder done while sequencer not waiting");

	a_flush_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FLUSH |=> !have_pend_q && state_q == S_IDLE)
		else $error("pending result left after flush");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |=> !out_valid_q)
		else $error("result directly after last item of tick");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import pms_pkg::*;

	localparam int N_CH = 8;
	localparam int PAT_LEN = 64;
	localparam int PWM_CH = 2;
	localparam logic [1:0] REQ_SPARE = 2'd3;
	localparam logic [1:0] CFG_SPARE = 2'd3;
	localparam int SETTLE_CYCLES = 120;
	localparam int STALL_LIMIT = 4000;
	localparam int N_PHASES = 6;
	localparam int ITEMS_PER_PHASE = 33;

	typedef struct {
		logic [1:0] kind;
		logic [2:0] chan;
		logic [5:0] idx;
		word_t      wrd;
		logic       en;
		logic [7:0] rat;
		word_t      lo;
		word_t      hi;
	} cmd_t;

	typedef struct {
		logic [2:0] chan;
		word_t      goal;
		logic       last;
	} goal_t;

	typedef struct {
		cmd_t  cmd;
		bit    typed;
		goal_t want;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  req_type;
	logic [2:0]  channel;
	logic [5:0]  index;
	word_t       word;
	logic        enable;
	logic [7:0]  ratio;
	word_t       bound_lo;
	word_t       bound_hi;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        out_valid;
	logic [2:0]  out_channel;
	word_t       goal;
	logic        last;

	multichannel_pattern_sequencer_top #(
		.NUM_CHANNELS(N_CH),
		.PATTERN_LEN(PAT_LEN),
		.PWM_CHANNELS(PWM_CH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.channel(channel),
		.index(index),
		.word(word),
		.enable(enable),
		.ratio(ratio),
		.bound_lo(bound_lo),
		.bound_hi(bound_hi),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_channel(out_channel),
		.goal(goal),
		.last(last)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// sequencer state as predicted
	logic [GAIN_W-1:0]     m_gain;
	logic [FS_W-1:0]       m_fs;
	logic [LIMIT_W-1:0]    m_pwm;
	logic [PRESCALE_W-1:0] m_presc;
	logic [COUNTER_W-1:0]  m_steps;
	int unsigned           m_pos [N_CH];
	word_t                 m_tbl [N_CH*PAT_LEN];
	logic                  m_en [N_CH];
	logic [7:0]            m_ratio [N_CH];
	word_t                 m_lo [N_CH];
	word_t                 m_hi [N_CH];

	goal_t new_goals[$];
	goal_t pending_goals[$];
	goal_t none;
	int    goal_errors = 0;
	int    stall_cycles = 0;

	function automatic cmd_t mk_cmd(logic [1:0] kind, logic [2:0] chan, logic [5:0] idx,
			word_t wrd, logic en, logic [7:0] rat, word_t lo, word_t hi);
		cmd_t c;
		c.kind = kind;
		c.chan = chan;
		c.idx = idx;
		c.wrd = wrd;
		c.en = en;
		c.rat = rat;
		c.lo = lo;
		c.hi = hi;
		return c;
	endfunction

	// goals caused by one item, left in new_goals
	function automatic void predict_goals(cmd_t c);
		logic [FS_W-1:0]       f;
		logic [PRESCALE_W-1:0] wrap;
		longint                prod;
		int                    val;
		goal_t                 g;
		new_goals.delete();
		case (c.kind)
			REQ_WORD: m_tbl[int'(c.chan)*PAT_LEN + int'(c.idx)] = c.wrd;
			REQ_CHAN: begin
				m_en[c.chan] = c.en;
				m_ratio[c.chan] = (c.rat == 8'd0) ? 8'd1 : c.rat;
				m_lo[c.chan] = c.lo;
				m_hi[c.chan] = c.hi;
			end
			REQ_TICK: begin
				f = m_fs;
				if (f < FS_MIN) f = FS_MIN;
				else if (f > FS_MAX) f = FS_MAX;
				wrap = PRESCALE_W'(2 * (TEMPO_BASE - int'(f)));
				m_presc = m_presc + 1'b1;
				if (m_presc >= wrap) begin
					m_presc = '0;
					m_steps = m_steps + 1'b1;
					for (int ch = 0; ch < N_CH; ch++) begin
						if (m_en[ch] && (m_steps % m_ratio[ch]) == 0) begin
							if (m_pos[ch] >= PAT_LEN) m_pos[ch] = 0;
							// q8.8 gain, truncated toward zero, then saturated
							prod = longint'(m_tbl[ch*PAT_LEN + m_pos[ch]]) * longint'(m_gain);
							prod = prod / 256;
							if (prod > 32767) prod = 32767;
							if (prod < -32768) prod = -32768;
							val = int'(prod);
							if (val > int'(m_hi[ch])) val = m_hi[ch];
							if (val < int'(m_lo[ch])) val = m_lo[ch];
							if (ch >= N_CH - PWM_CH && val > int'(m_pwm)) val = m_pwm;
							m_pos[ch] = m_pos[ch] + 1;
							g.chan = 3'(ch);
							g.goal = 16'(val);
							g.last = 1'b0;
							new_goals.push_back(g);
						end
					end
					if (new_goals.size() > 0) new_goals[new_goals.size()-1].last = 1'b1;
				end
			end
			default: ;
		endcase
	endfunction

	task automatic send_cmd(cmd_t c, int gap, bit typed, goal_t want);
		@(negedge clk);
		start <= 1'b1;
		req_type <= c.kind;
		channel <= c.chan;
		index <= c.idx;
		word <= c.wrd;
		enable <= c.en;
		ratio <= c.rat;
		bound_lo <= c.lo;
		bound_hi <= c.hi;
		do @(posedge clk); while (busy);
		predict_goals(c);
		if (typed) pending_goals.push_back(want);
		else foreach (new_goals[i]) pending_goals.push_back(new_goals[i]);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_GAIN: m_gain = data;
			CFG_FREQ: m_fs = data[FS_W-1:0];
			CFG_PWM:  m_pwm = data[LIMIT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// stop sending, let every goal arrive, then let a tick with no goal finish
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_goals.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		goal_t want;
		if (arst_n && out_valid) begin
			if (pending_goals.size() == 0) begin
				goal_errors++;
				if (goal_errors <= 10)
					$display("unexpected goal: ch %0d goal %0d last %0d",
						out_channel, goal, last);
			end else begin
				want = pending_goals.pop_front();
				if (out_channel !== want.chan || goal !== want.goal || last !== want.last) begin
					goal_errors++;
					if (goal_errors <= 10)
						$display("goal mismatch: want ch %0d goal %0d last %0d, got ch %0d goal %0d last %0d",
							want.chan, want.goal, want.last, out_channel, goal, last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		row_t        rows[$];
		cmd_t        c;
		int          gap;
		int          pick;
		logic [15:0] g_val;
		logic [15:0] d;
		logic [2:0]  f_val;
		logic [6:0]  w_val;

		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_TICK;
		channel = '0;
		index = '0;
		word = '0;
		enable = 1'b0;
		ratio = '0;
		bound_lo = '0;
		bound_hi = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_GAIN;
		cfg_data = '0;
		none.chan = '0;
		none.goal = '0;
		none.last = 1'b0;

		m_gain = GAIN_RESET;
		m_fs = FS_MIN;
		m_pwm = '0;
		m_presc = '0;
		m_steps = '0;
		for (int i = 0; i < N_CH*PAT_LEN; i++) m_tbl[i] = '0;
		for (int i = 0; i < N_CH; i++) begin
			m_pos[i] = 0;
			m_en[i] = 1'b0;
			m_ratio[i] = 8'd1;
			m_lo[i] = '0;
			m_hi[i] = UPPER_RESET;
		end

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// fastest tempo so the directed ticks wrap on every second tick
		write_reg(CFG_GAIN, GAIN_RESET);
		write_reg(CFG_FREQ, 16'(FS_MAX));
		write_reg(CFG_PWM, 16'd0);

		rows.push_back('{mk_cmd(REQ_CHAN, 3'd0, 6'd0, 16'sd0, 1'b1, 8'd0,
			16'sh8000, 16'sh7fff), 1'b0, none});
		rows.push_back('{mk_cmd(REQ_WORD, 3'd0, 6'd0, 16'sh7fff, 1'b0, 8'd0,
			16'sd0, 16'sd0), 1'b0, none});
		rows.push_back('{mk_cmd(REQ_WORD, 3'd0, 6'd63, 16'sh8000, 1'b0, 8'd0,
			16'sd0, 16'sd0), 1'b0, none});
		// tick without wrap, then a wrap playing the full-scale word at unity gain
		rows.push_back('{mk_cmd(REQ_TICK, 3'd0, 6'd0, 16'sd0, 1'b0, 8'd0,
			16'sd0, 16'sd0), 1'b0, none});
		rows.push_back('{mk_cmd(REQ_TICK, 3'd0, 6'd0, 16'sd0, 1'b0, 8'd0,
			16'sd0, 16'sd0), 1'b1, '{3'd0, 16'sh7fff, 1'b1}});
		rows.push_back('{mk_cmd(REQ_CHAN, 3'd7, 6'd0, 16'sd0, 1'b1, 8'd2,
			-16'sd5, 16'sh7fff), 1'b0, none});
		rows.push_back('{mk_cmd(REQ_WORD, 3'd7, 6'd0, 16'sd50, 1'b0, 8'd0,
			16'sd0, 16'sd0), 1'b0, none});
		rows.push_back('{mk_cmd(REQ_TICK, 3'd7, 6'd63, 16'sh7fff, 1'b1, 8'd255,
			16'sh7fff, 16'sh8000), 1'b0, none});
		// pwm channel capped at a limit of zero
		rows.push_back('{mk_cmd(REQ_TICK, 3'd0, 6'd0, 16'sd0, 1'b0, 8'd0,
			16'sd0, 16'sd0), 1'b0, none});
		rows.push_back('{mk_cmd(REQ_SPARE, 3'd7, 6'd63, 16'sh7fff, 1'b1, 8'd255,
			16'sh7fff, 16'sh7fff), 1'b0, none});
		rows.push_back('{mk_cmd(REQ_CHAN, 3'd0, 6'd0, 16'sd0, 1'b0, 8'd255,
			16'sd0, 16'sd0), 1'b0, none});
		rows.push_back('{mk_cmd(REQ_TICK, 3'd0, 6'd0, 16'sd0, 1'b0, 8'd0,
			16'sd0, 16'sd0), 1'b0, none});
		// wrap on an odd count, ratio 2 channel stays silent
		rows.push_back('{mk_cmd(REQ_TICK, 3'd0, 6'd0, 16'sd0, 1'b0, 8'd0,
			16'sd0, 16'sd0), 1'b0, none});
		// min above max: min wins
		rows.push_back('{mk_cmd(REQ_CHAN, 3'd1, 6'd0, 16'sd0, 1'b1, 8'd1,
			16'sd10, -16'sd10), 1'b0, none});
		rows.push_back('{mk_cmd(REQ_WORD, 3'd1, 6'd0, -16'sd30000, 1'b0, 8'd0,
			16'sd0, 16'sd0), 1'b0, none});
		rows.push_back('{mk_cmd(REQ_TICK, 3'd0, 6'd0, 16'sd0, 1'b0, 8'd0,
			16'sd0, 16'sd0), 1'b0, none});
		rows.push_back('{mk_cmd(REQ_TICK, 3'd0, 6'd0, 16'sd0, 1'b0, 8'd0,
			16'sd0, 16'sd0), 1'b0, none});
		rows.push_back('{mk_cmd(REQ_CHAN, 3'd6, 6'd0, 16'sd0, 1'b1, 8'd1,
			16'sh8000, 16'sh7fff), 1'b0, none});
		rows.push_back('{mk_cmd(REQ_WORD, 3'd6, 6'd0, 16'sh8000, 1'b0, 8'd0,
			16'sd0, 16'sd0), 1'b0, none});
		rows.push_back('{mk_cmd(REQ_CHAN, 3'd7, 6'd0, 16'sd0, 1'b0, 8'd1,
			16'sd0, 16'sd100), 1'b0, none});
		rows.push_back('{mk_cmd(REQ_CHAN, 3'd1, 6'd0, 16'sd0, 1'b0, 8'd1,
			16'sd0, 16'sd100), 1'b0, none});
		rows.push_back('{mk_cmd(REQ_TICK, 3'd0, 6'd0, 16'sd0, 1'b0, 8'd0,
			16'sd0, 16'sd0), 1'b0, none});
		// negative full scale passes the pwm cap untouched
		rows.push_back('{mk_cmd(REQ_TICK, 3'd0, 6'd0, 16'sd0, 1'b0, 8'd0,
			16'sd0, 16'sd0), 1'b1, '{3'd6, 16'sh8000, 1'b1}});
		rows.push_back('{mk_cmd(REQ_CHAN, 3'd0, 6'd0, 16'sd0, 1'b1, 8'd1,
			16'sh8000, 16'sh7fff), 1'b0, none});

		foreach (rows[i]) begin
			gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 18)) : 0;
			send_cmd(rows[i].cmd, gap, rows[i].typed, rows[i].want);
		end
		settle();

		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
				0: begin g_val = 16'd256; f_val = 3'd0; w_val = 7'd100; end
				1: begin g_val = 16'hffff; f_val = 3'd7; w_val = 7'd127; end
				2: begin g_val = 16'd0; f_val = 3'd5; w_val = 7'd0; end
				3: begin g_val = 16'($urandom); f_val = 3'd6; w_val = 7'($urandom_range(0, 100)); end
				4: begin g_val = 16'($urandom_range(0, 512)); f_val = 3'd3; w_val = 7'($urandom); end
				default: begin
					g_val = 16'($urandom);
					f_val = 3'd5;
					w_val = 7'($urandom_range(0, 100));
				end
			endcase
			write_reg(CFG_GAIN, g_val);
			// upper data bits are don't-care for the narrow registers
			d = 16'($urandom);
			d[FS_W-1:0] = f_val;
			write_reg(CFG_FREQ, d);
			d = 16'($urandom);
			d[LIMIT_W-1:0] = w_val;
			write_reg(CFG_PWM, d);
			if (p == 2) write_reg(CFG_SPARE, 16'($urandom));

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				c = mk_cmd(REQ_TICK, 3'($urandom), 6'($urandom), 16'($urandom), 1'($urandom),
					8'($urandom), 16'($urandom), 16'($urandom));
				pick = $urandom_range(0, 99);
				if (pick >= 97) begin
					c.kind = REQ_SPARE;
				end else if (pick >= 90) begin
					c.kind = REQ_CHAN;
					case ($urandom_range(0, 3))
						0, 1: c.rat = 8'd1;
						2: c.rat = 8'($urandom_range(0, 4));
						default: ;
					endcase
					c.en = ($urandom_range(0, 7) != 0);
					if ($urandom_range(0, 7) != 0) begin
						c.lo = 16'(-int'($urandom_range(0, 32768)));
						c.hi = 16'($urandom_range(0, 32767));
					end
					// channel 0 keeps playing every step so its position wraps
					if (c.chan == 3'd0) begin
						c.en = 1'b1;
						c.rat = 8'($urandom_range(0, 1));
					end
				end else if (pick >= 75) begin
					c.kind = REQ_WORD;
					// mostly fill the words about to be played
					if ($urandom_range(0, 3) != 0)
						c.idx = 6'(m_pos[c.chan] + $urandom_range(0, 3));
				end
				gap = (p != N_PHASES-1 && $urandom_range(0, 3) == 0) ?
					int'($urandom_range(1, 18)) : 0;
				send_cmd(c, gap, 1'b0, none);
			end
			settle();
		end

		if (goal_errors == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end

endmodule
